// ----- rtl/iss_pkg.sv -----
package iss_pkg;

	// Fixed field widths of the payload
	localparam int DATA_W  = 32;
	localparam int TALLY_W = 11;

	// One input item
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     end_of_set;
	} in_item_t;

	// One result item
	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic [TALLY_W-1:0]       swap_total;
		logic                     final_result;
	} out_item_t;

	// Broadcast command to every cell of the chain
	typedef struct packed {
		logic                     insert;
		logic                     drain;
		logic signed [DATA_W-1:0] value;
	} cell_cmd_t;

	// Controller states
	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} iss_state_t;

endpackage

// ----- rtl/insertion_sort_swap_count.sv -----
// Streaming insertion sorter with inversion count. Values arrive one per transfer and
// drop into a chain of MAX_ELEMENTS cells kept in ascending signed order; every cell
// compares against the new value at once. The running swap total grows by the number
// of held values strictly greater than the new one. A value flagged end_of_set, or one
// that fills the chain, closes the set: the chain then shifts out towards cell 0, one
// result per cycle while out_ready is high, and input is refused until the largest
// value (final_result set) has been taken.
module insertion_sort_swap_count #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  iss_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output iss_pkg::out_item_t out_data
);
	import iss_pkg::*;

	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	iss_state_t state_q, state_d;

	logic [CNT_W-1:0]   fill_q;
	logic [TALLY_W-1:0] tally_q;

	cell_cmd_t cmd;

	logic signed [DATA_W-1:0] cell_val [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0]  vld_vec;
	logic [MAX_ELEMENTS-1:0]  ins_vec;
	logic [MAX_ELEMENTS-1:0]  first_ins;
	logic [IDX_W-1:0]         pos;
	logic [CNT_W-1:0]         greater_cnt;
	logic                     in_xfer;
	logic                     out_xfer;
	logic                     close_set;

	// Cell chain
	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		logic signed [DATA_W-1:0] l_val, r_val;
		logic                     l_vld, l_ins, r_vld;

		if (i == 0) begin : g_bottom
			assign l_val = '0;
			assign l_vld = 1'b1;
			assign l_ins = 1'b0;
		end else begin : g_mid_l
			assign l_val = cell_val[i-1];
			assign l_vld = vld_vec[i-1];
			assign l_ins = ins_vec[i-1];
		end

		if (i == MAX_ELEMENTS - 1) begin : g_top
			assign r_val = '0;
			assign r_vld = 1'b0;
		end else begin : g_mid_r
			assign r_val = cell_val[i+1];
			assign r_vld = vld_vec[i+1];
		end

		iss_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_val  (l_val),
			.left_vld  (l_vld),
			.left_ins  (l_ins),
			.right_val (r_val),
			.right_vld (r_vld),
			.val       (cell_val[i]),
			.vld       (vld_vec[i]),
			.ins       (ins_vec[i])
		);
	end

	// Locate the insertion point: the lowest displaced cell
	assign first_ins = ins_vec & ~{ins_vec[MAX_ELEMENTS-2:0], 1'b0};

	always_comb begin
		pos = '0;
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			if (first_ins[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
	end

	assign greater_cnt = fill_q - CNT_W'(pos);
	assign in_xfer     = in_valid && in_ready;
	assign out_xfer    = out_valid && out_ready;
	assign close_set   = in_data.end_of_set || (fill_q == CNT_W'(MAX_ELEMENTS - 1));

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, chain commands and port outputs
	always_comb begin
		state_d               = state_q;
		in_ready              = 1'b0;
		out_valid             = 1'b0;
		cmd.insert            = 1'b0;
		cmd.drain             = 1'b0;
		cmd.value             = in_data.value;
		out_data.sorted_value = cell_val[0];
		out_data.swap_total   = tally_q;
		out_data.final_result = !vld_vec[1];
		unique case (state_q)
			ST_FILL: begin
				in_ready   = 1'b1;
				cmd.insert = in_valid;
				if (in_valid && close_set) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				out_valid = vld_vec[0];
				cmd.drain = vld_vec[0] && out_ready;
				if (cmd.drain && out_data.final_result) begin
					state_d = ST_FILL;
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	// Fill count and swap tally: grow on insert; fill clears at close, tally at drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			tally_q <= '0;
		end else if (in_xfer) begin
			tally_q <= tally_q + TALLY_W'(greater_cnt);
			fill_q  <= close_set ? '0 : fill_q + 1'b1;
		end else if (out_xfer && out_data.final_result) begin
			tally_q <= '0;
		end
	end

endmodule

// ----- rtl/iss_cell.sv -----
module iss_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  iss_pkg::cell_cmd_t               cmd,
	input  logic signed [iss_pkg::DATA_W-1:0] left_val,
	input  logic                             left_vld,
	input  logic                             left_ins,
	input  logic signed [iss_pkg::DATA_W-1:0] right_val,
	input  logic                             right_vld,
	output logic signed [iss_pkg::DATA_W-1:0] val,
	output logic                             vld,
	output logic                             ins
);
	import iss_pkg::*;

	logic signed [DATA_W-1:0] val_q;
	logic                     vld_q;

	// Flag a slot that the new value displaces: empty, or holding a strictly greater value
	assign ins = !vld_q || (val_q > cmd.value);
	assign val = val_q;
	assign vld = vld_q;

	// Take the left neighbour's value when it moves up too, else the new value; drain leftwards
	always_ff @(posedge clk) begin
		if (cmd.insert && ins) begin
			val_q <= left_ins ? left_val : cmd.value;
		end else if (cmd.drain) begin
			val_q <= right_val;
		end
	end

	// Occupancy grows from the bottom of the chain and follows the drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.insert && ins) begin
			vld_q <= vld_q || left_vld;
		end else if (cmd.drain) begin
			vld_q <= right_vld;
		end
	end

endmodule

// ----- dv/iss_checker.sv -----
`timescale 1ns / 100ps

module iss_checker #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  iss_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  iss_pkg::out_item_t out_data,
	output int                 mismatches,
	output int                 due_count
);

	// Shadow copy of the sorted chain and the running inversion tally
	logic signed [iss_pkg::DATA_W-1:0]  held [CAPACITY];
	int                                 held_n;
	logic        [iss_pkg::TALLY_W-1:0] inv_tally;

	// Sorted results still owed by the block, oldest first
	iss_pkg::out_item_t sorted_due [$];

	// Print one line per mismatch and count it
	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Insert one value after every held value not greater than it; close the set
	// on the flagged item or when the chain is full
	task automatic absorb_value(input logic signed [iss_pkg::DATA_W-1:0] v, input logic eos);
		int                 slot;
		iss_pkg::out_item_t r;
		slot = 0;
		while (slot < held_n && held[slot] <= v)
			slot++;
		for (int i = held_n; i > slot; i--)
			held[i] = held[i-1];
		held[slot] = v;
		inv_tally  = inv_tally + iss_pkg::TALLY_W'(held_n - slot);
		held_n++;
		if (eos || held_n == CAPACITY) begin
			for (int i = 0; i < held_n; i++) begin
				r.sorted_value = held[i];
				r.swap_total   = inv_tally;
				r.final_result = (i == held_n - 1);
				sorted_due.push_back(r);
			end
			held_n    = 0;
			inv_tally = '0;
		end
	endtask

	// Compare one taken result against the oldest owed one
	task automatic take_result(input iss_pkg::out_item_t got);
		iss_pkg::out_item_t want;
		if (sorted_due.size() == 0) begin
			flag_mismatch("unexpected result", got.sorted_value, '0);
		end else begin
			want = sorted_due.pop_front();
			if (got.sorted_value !== want.sorted_value)
				flag_mismatch("sorted_value", got.sorted_value, want.sorted_value);
			if (got.swap_total !== want.swap_total)
				flag_mismatch("swap_total", 32'(got.swap_total), 32'(want.swap_total));
			if (got.final_result !== want.final_result)
				flag_mismatch("final_result", 32'(got.final_result), 32'(want.final_result));
		end
	endtask

	// Watch both channels; inputs first so a closing transfer is owed before any result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_n    = 0;
			inv_tally = '0;
			sorted_due.delete();
			due_count <= 0;
		end else begin
			if (in_valid && in_ready)
				absorb_value($signed(in_data.value), in_data.end_of_set);
			if (out_valid && out_ready)
				take_result(out_data);
			due_count <= sorted_due.size();
		end
	end

	initial mismatches = 0;

endmodule

// ----- dv/insertion_sort_swap_count_tb.sv -----
`timescale 1ns / 100ps

module insertion_sort_swap_count_tb;

	localparam int CAPACITY = 64;
	localparam int ITEM_GOAL = 400;
	localparam int HOLD_CYCLES = 400;

	typedef enum int {
		SET_RANDOM,
		SET_NARROW,
		SET_EXTREME,
		SET_DESCEND
	} set_flavour_t;

	typedef enum int {
		RX_OPEN,
		RX_MOSTLY,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	iss_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	iss_pkg::out_item_t out_data;

	int mismatches;
	int due_count;
	int hold_req;
	int hold_done;
	int burst_left;
	int sent;

	logic signed [iss_pkg::DATA_W-1:0] set_vals [$];

	insertion_sort_swap_count #(
		.MAX_ELEMENTS(CAPACITY)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	iss_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.mismatches(mismatches),
		.due_count (due_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one value and hold it until the transfer; idle between bursts
	task automatic offer_value(input logic signed [iss_pkg::DATA_W-1:0] v, input logic eos);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
				: $urandom_range(1, 12);
		end
		in_valid           <= 1'b1;
		in_data.value      <= v;
		in_data.end_of_set <= eos;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		burst_left--;
		sent++;
	endtask

	// Send the staged set; flag the last value only when asked
	task automatic send_set(input logic close);
		for (int i = 0; i < set_vals.size(); i++)
			offer_value(set_vals[i], close && (i == set_vals.size() - 1));
	endtask

	// Stage a set of n values of the given flavour
	task automatic build_set(input int n, input set_flavour_t flavour);
		logic signed [iss_pkg::DATA_W-1:0] base;
		base = $signed($urandom());
		set_vals.delete();
		for (int i = 0; i < n; i++) begin
			case (flavour)
				SET_NARROW:  set_vals.push_back($signed($urandom_range(0, 6)) - 3);
				SET_EXTREME: begin
					case ($urandom_range(0, 3))
						0: set_vals.push_back(32'sh8000_0000);
						1: set_vals.push_back(32'sh7fff_ffff);
						2: set_vals.push_back(32'sd0);
						default: set_vals.push_back(-32'sd1);
					endcase
				end
				SET_DESCEND: set_vals.push_back(base - i);
				default:     set_vals.push_back($signed($urandom()));
			endcase
		end
	endtask

	// Receiver: own stall pattern, with an occasional long hold-off on request
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       tick;
		mode      = RX_OPEN;
		mode_left = 0;
		tick      = 0;
		out_ready = 1'b0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_done != hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_done++;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(32, 256);
				end
				mode_left--;
				tick++;
				case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_MOSTLY: out_ready <= ($urandom_range(0, 99) < 75);
					RX_SPARSE: out_ready <= ($urandom_range(0, 99) < 25);
					default:   out_ready <= (tick % 4 == 0);
				endcase
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int           n;
		set_flavour_t flavour;
		in_valid   = 1'b0;
		in_data    = '0;
		arst_n     = 1'b0;
		hold_req   = 0;
		burst_left = 0;
		sent       = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Single-value set at the most negative value
		set_vals = '{32'sh8000_0000};
		send_set(1'b1);
		// Field extremes mixed around zero
		set_vals = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1};
		send_set(1'b1);
		// Equal values keep arrival order and add no swaps among themselves
		set_vals = '{32'sd5, 32'sd5, -32'sd3, 32'sd5, -32'sd3};
		send_set(1'b1);
		// Strictly descending run gives the largest tally for its size
		build_set(8, SET_DESCEND);
		send_set(1'b1);

		// Full chain closes the set without the flag, then with it
		build_set(CAPACITY, SET_DESCEND);
		send_set(1'b0);
		build_set(CAPACITY, SET_RANDOM);
		send_set(1'b1);

		// Long receiver hold-off while the sender keeps offering
		hold_req++;
		build_set(10, SET_RANDOM);
		send_set(1'b1);

		while (sent < ITEM_GOAL) begin
			case ($urandom_range(0, 19))
				0:       n = CAPACITY;
				1, 2, 3: n = $urandom_range(11, 40);
				default: n = $urandom_range(1, 10);
			endcase
			flavour = set_flavour_t'($urandom_range(0, 3));
			build_set(n, flavour);
			if (sent > ITEM_GOAL / 2 && hold_req == 1)
				hold_req++;
			send_set((n < CAPACITY) ? 1'b1 : 1'($urandom_range(0, 1)));
		end
		in_valid <= 1'b0;

		// Drain what is still owed, then let the block settle
		while (due_count != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Timeout
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
